@@ design/ffba_pkg.sv @@
`default_nettype none
package ffba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int META_BYTES = 32;
    localparam int SIZE_W     = 27;
    localparam int OFF_W      = 32;

    localparam logic [SIZE_W-1:0] RESET_MAX_REQUEST   = SIZE_W'(100000000);
    localparam logic [OFF_W-1:0]  RESET_HEAP_CAPACITY = OFF_W'(1048576);

    // request codes
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_REALLOC = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_NOP      = 2'd3;

    // register indexes
    localparam logic REG_MAX_REQUEST   = 1'b0;
    localparam logic REG_HEAP_CAPACITY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_GROW,
        S_REL,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_APPEND,
        OP_SET_FREE,
        OP_CLR_FREE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic [IDX_W-1:0]        idx;
        logic [SIZE_W-1:0]       size;
        logic [OFF_W-1:0]        offset;
        logic                    scan;
        logic                    shift;
        logic                    start;
    } t_cell_cmd;

    typedef struct packed {
        logic                    hit;
        logic                    free;
        logic [SIZE_W-1:0]       size;
        logic [OFF_W-1:0]        offset;
    } t_cell_rd;

endpackage
`default_nettype wire

@@ design/ffba_req_if.sv @@
`default_nettype none
interface ffba_req_if;
    import ffba_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [SIZE_W-1:0] req_size;
    logic              handle_valid;
    logic [IDX_W-1:0]  block_handle;

    modport source (output valid, req_type, req_size, handle_valid, block_handle,
                    input ready);
    modport sink   (input valid, req_type, req_size, handle_valid, block_handle,
                    output ready);
endinterface
`default_nettype wire

@@ design/ffba_rsp_if.sv @@
`default_nettype none
interface ffba_rsp_if;
    import ffba_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [IDX_W-1:0]  result_index;
    logic [OFF_W-1:0]  payload_offset;
    logic [CNT_W-1:0]  free_blocks;
    logic [OFF_W-1:0]  free_bytes;
    logic [CNT_W-1:0]  allocated_blocks;
    logic [OFF_W-1:0]  allocated_bytes;

    modport source (output valid, status, result_index, payload_offset, free_blocks,
                    free_bytes, allocated_blocks, allocated_bytes, input ready);
    modport sink   (input valid, status, result_index, payload_offset, free_blocks,
                    free_bytes, allocated_blocks, allocated_bytes, output ready);
endinterface
`default_nettype wire

@@ design/ffba_cell.sv @@
`default_nettype none
module ffba_cell
    import ffba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire t_cell_cmd        i_cmd,
    input  wire logic             i_tok,
    output logic                  o_tok,
    output t_cell_rd              o_rd
);

    logic              r_free;
    logic              r_tok;
    logic [SIZE_W-1:0] r_size;
    logic [OFF_W-1:0]  r_offset;
    logic              w_match;
    logic              w_sel;

    assign w_match = (i_idx == i_cmd.idx);
    assign w_sel   = i_cmd.scan ? r_tok : w_match;
    assign o_tok   = r_tok;

    always_comb begin
        o_rd.hit    = i_cmd.scan & r_tok & r_free & (r_size >= i_cmd.size);
        o_rd.free   = w_sel & r_free;
        o_rd.size   = w_sel ? r_size : '0;
        o_rd.offset = w_sel ? r_offset : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= 1'b0;
            r_tok  <= 1'b0;
        end else begin
            // token enters at cell 0 and walks one cell a cycle while shift is set
            if (i_cmd.start) begin
                r_tok <= (i_idx == '0);
            end else if (i_cmd.shift) begin
                r_tok <= i_tok;
            end
            if (w_match) begin
                case (i_cmd.op)
                    OP_APPEND:   r_free <= 1'b0;
                    OP_SET_FREE: r_free <= 1'b1;
                    OP_CLR_FREE: r_free <= 1'b0;
                    default:     r_free <= r_free;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_match && i_cmd.op == OP_APPEND) begin
            r_size   <= i_cmd.size;
            r_offset <= i_cmd.offset;
        end
    end

endmodule
`default_nettype wire

@@ design/first_fit_block_allocator_top.sv @@
`default_nettype none
// first-fit block allocator over a row of block record cells
// requests arrive on i_req (valid/ready); one response beat per request leaves
// on o_rsp with status, granted index and offset and the running counts
// each cell holds one record (size, free mark, offset); a search token walks
// the row one cell per cycle, and the first free cell big enough wins
// a free, bad size, keep in place or no operation goes from the check step
// straight to done; an allocate scans the existing blocks until a free one fits,
// takes the grow step if none fits, and then the release step before done
// one request is worked at a time; a new request beat is taken as soon as
// the previous result sits in the output register, even if not yet taken
// when the receiver stalls, the finished result waits in that register and
// the next request holds in its final step until the slot frees
// the apb port writes max_request (offset 0) and heap_capacity (offset 4);
// pready is always high, reads return the register value
// reset clears all free marks, counts and the heap top and loads the
// register defaults; no clearing pass is needed
module first_fit_block_allocator_top
    import ffba_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ffba_req_if.sink         i_req,
    ffba_rsp_if.source       o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [OFF_W-1:0] META = OFF_W'(META_BYTES);

    t_state            r_state, n_state;

    // config registers
    logic [SIZE_W-1:0] r_max_req;
    logic [OFF_W-1:0]  r_cap;

    // latched request
    logic [1:0]        r_type;
    logic [SIZE_W-1:0] r_size;
    logic              r_hv;
    logic [IDX_W-1:0]  r_h;

    // realloc bookkeeping
    logic              r_realloc;
    logic              r_old_free;
    logic [SIZE_W-1:0] r_old_size;

    // running state
    logic [CNT_W-1:0]  r_blk_cnt;
    logic [CNT_W-1:0]  r_free_cnt;
    logic [OFF_W-1:0]  r_free_bytes;
    logic [OFF_W-1:0]  r_used_bytes;
    logic [OFF_W-1:0]  r_top;
    logic [CNT_W-1:0]  r_pos;

    // result
    logic [1:0]        r_status;
    logic [IDX_W-1:0]  r_ridx;
    logic [OFF_W-1:0]  r_roff;
    logic              r_ovalid;

    t_cell_cmd         w_cmd;
    t_cell_rd          w_cell_rd [MAX_BLOCKS];
    logic              w_tok [MAX_BLOCKS];
    t_cell_rd          w_rd;

    logic              w_accept;
    logic              w_cfg_wr;
    logic              w_bad;
    logic              w_h_in;
    logic [OFF_W:0]    w_need;
    logic              w_grow_ok;
    logic              w_scan_end;
    logic              w_slot_free;
    logic              w_size_op;
    logic              w_do_free;
    logic              w_rel;

    // ---------------- cell row ----------------
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_tok   ((g == 0) ? 1'b0 : w_tok[(g == 0) ? 0 : g - 1]),
            .o_tok   (w_tok[g]),
            .o_rd    (w_cell_rd[g])
        );
    end

    // only one cell is selected at a time, so an or merges the row
    always_comb begin
        w_rd = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            w_rd = w_rd | w_cell_rd[i];
        end
    end

    // ---------------- decode ----------------
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_cfg_wr    = psel && penable && pwrite;
    assign w_bad       = (r_size == '0) || (r_size > r_max_req);
    assign w_h_in      = {1'b0, r_h} < r_blk_cnt;
    assign w_need      = {1'b0, r_top} + {1'b0, META} + (OFF_W+1)'(r_size);
    assign w_grow_ok   = (r_blk_cnt < CNT_W'(MAX_BLOCKS)) && (w_need <= {1'b0, r_cap});
    assign w_scan_end  = r_pos >= r_blk_cnt;
    assign w_slot_free = !r_ovalid || o_rsp.ready;
    assign w_size_op   = (r_type == REQ_ALLOC) || (r_type == REQ_REALLOC);
    assign w_do_free   = (r_type == REQ_FREE) && r_hv && w_h_in && !w_rd.free;
    assign w_rel       = r_realloc && (r_status == ST_OK) && !r_old_free;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_DONE;
                if (w_size_op && !w_bad) begin
                    if (r_type == REQ_ALLOC || !r_hv) begin
                        n_state = S_SCAN;
                    end else if (w_h_in && r_size > w_rd.size) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_GROW;
                end else if (w_rd.hit) begin
                    n_state = S_REL;
                end
            end
            S_GROW: n_state = S_REL;
            S_REL:  n_state = S_DONE;
            S_DONE: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        i_req.ready  = 1'b0;
        w_cmd.op     = OP_NONE;
        w_cmd.idx    = r_h;
        w_cmd.size   = r_size;
        w_cmd.offset = r_top + META;
        w_cmd.scan   = 1'b0;
        w_cmd.shift  = 1'b0;
        w_cmd.start  = 1'b0;
        unique case (r_state)
            S_IDLE: i_req.ready = 1'b1;
            S_CHECK: begin
                w_cmd.start = 1'b1;
                if (w_do_free) w_cmd.op = OP_SET_FREE;
            end
            S_SCAN: begin
                w_cmd.scan  = 1'b1;
                w_cmd.shift = 1'b1;
                w_cmd.idx   = r_pos[IDX_W-1:0];
                if (!w_scan_end && w_rd.hit) w_cmd.op = OP_CLR_FREE;
            end
            S_GROW: begin
                w_cmd.idx = r_blk_cnt[IDX_W-1:0];
                if (w_grow_ok) w_cmd.op = OP_APPEND;
            end
            S_REL: begin
                if (w_rel) w_cmd.op = OP_SET_FREE;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEAP_CAPACITY) ? r_cap : 32'(r_max_req);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_req <= RESET_MAX_REQUEST;
            r_cap     <= RESET_HEAP_CAPACITY;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_MAX_REQUEST) begin
                r_max_req <= pwdata[SIZE_W-1:0];
            end else begin
                r_cap <= pwdata;
            end
        end
    end

    // ---------------- request latch and realloc bookkeeping ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_type <= i_req.req_type;
            r_size <= i_req.req_size;
            r_hv   <= i_req.handle_valid;
            r_h    <= i_req.block_handle;
        end
        if (r_state == S_CHECK) begin
            r_old_free <= w_rd.free;
            r_old_size <= w_rd.size;
        end
    end

    // ---------------- allocator state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_cnt    <= '0;
            r_free_cnt   <= '0;
            r_free_bytes <= '0;
            r_used_bytes <= '0;
            r_top        <= '0;
            r_pos        <= '0;
            r_realloc    <= 1'b0;
            r_status     <= ST_NOP;
            r_ridx       <= '0;
            r_roff       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_realloc <= 1'b0;
                        r_status  <= ST_NOP;
                        r_ridx    <= '0;
                        r_roff    <= '0;
                    end
                end
                S_CHECK: begin
                    r_pos <= '0;
                    if (w_size_op) begin
                        if (w_bad) begin
                            r_status <= ST_BAD_SIZE;
                        end else if (r_type == REQ_REALLOC && r_hv && w_h_in) begin
                            if (r_size <= w_rd.size) begin
                                // fits in place
                                r_status <= ST_OK;
                                r_ridx   <= r_h;
                                r_roff   <= w_rd.offset;
                            end else begin
                                r_realloc <= 1'b1;
                            end
                        end
                    end else if (w_do_free) begin
                        r_status     <= ST_OK;
                        r_free_cnt   <= r_free_cnt + 1'b1;
                        r_free_bytes <= r_free_bytes + OFF_W'(w_rd.size);
                    end
                end
                S_SCAN: begin
                    if (!w_scan_end) begin
                        if (w_rd.hit) begin
                            r_status     <= ST_OK;
                            r_ridx       <= r_pos[IDX_W-1:0];
                            r_roff       <= w_rd.offset;
                            r_free_cnt   <= r_free_cnt - 1'b1;
                            r_free_bytes <= r_free_bytes - OFF_W'(w_rd.size);
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                S_GROW: begin
                    if (w_grow_ok) begin
                        r_status     <= ST_OK;
                        r_ridx       <= r_blk_cnt[IDX_W-1:0];
                        r_roff       <= r_top + META;
                        r_top        <= w_need[OFF_W-1:0];
                        r_used_bytes <= r_used_bytes + OFF_W'(r_size);
                        r_blk_cnt    <= r_blk_cnt + 1'b1;
                    end else begin
                        r_status <= ST_NO_SPACE;
                    end
                end
                S_REL: begin
                    // old block of a moved realloc is released last
                    if (w_rel) begin
                        r_free_cnt   <= r_free_cnt + 1'b1;
                        r_free_bytes <= r_free_bytes + OFF_W'(r_old_size);
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && w_slot_free) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_slot_free) begin
            o_rsp.status           <= r_status;
            o_rsp.result_index     <= r_ridx;
            o_rsp.payload_offset   <= r_roff;
            o_rsp.free_blocks      <= r_free_cnt;
            o_rsp.free_bytes       <= r_free_bytes;
            o_rsp.allocated_blocks <= r_blk_cnt;
            o_rsp.allocated_bytes  <= r_used_bytes;
        end
    end

    assign o_rsp.valid = r_ovalid;

`ifndef ASSERT_OFF
    a_free_le_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= r_blk_cnt)
        else $error("free block count above block count");

    a_blk_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blk_cnt <= CNT_W'(MAX_BLOCKS))
        else $error("block count above table size");

    a_scan_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_pos <= r_blk_cnt)
        else $error("scan position past last block");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |->
            (o_rsp.result_index == '0 && o_rsp.payload_offset == '0))
        else $error("failed result carries an index or offset");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN && !w_scan_end |-> $countones(w_rd.hit) <= 1)
        else $error("more than one hit in scan");
`endif

endmodule
`default_nettype wire

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffba_pkg::*;

    // result record as seen on the response channel
    typedef struct {
        logic [1:0]       status;
        logic [IDX_W-1:0] result_index;
        logic [OFF_W-1:0] payload_offset;
        logic [CNT_W-1:0] free_blocks;
        logic [OFF_W-1:0] free_bytes;
        logic [CNT_W-1:0] allocated_blocks;
        logic [OFF_W-1:0] allocated_bytes;
    } t_grant;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    ffba_req_if req_ch();
    ffba_rsp_if rsp_ch();

    first_fit_block_allocator_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state: shadow copy of the block table
    logic [SIZE_W-1:0] sh_size [MAX_BLOCKS];
    logic              sh_free [MAX_BLOCKS];
    logic [OFF_W-1:0]  sh_off  [MAX_BLOCKS];
    int unsigned       sh_count, sh_top, sh_free_cnt, sh_free_bytes, sh_used_bytes;
    logic [SIZE_W-1:0] cfg_max_req = RESET_MAX_REQUEST;
    logic [OFF_W-1:0]  cfg_cap = RESET_HEAP_CAPACITY;

    t_grant expected_grants[$];
    int     error_count = 0;
    longint cycle_count = 0;

    // first-fit search, else append at heap top
    function automatic logic [1:0] first_fit(input logic [SIZE_W-1:0] sz,
                                             output int unsigned slot);
        longint need;
        slot = 0;
        for (int i = 0; i < sh_count; i++) begin
            if (sh_free[i] && sh_size[i] >= sz) begin
                sh_free[i] = 1'b0;
                sh_free_cnt--;
                sh_free_bytes -= sh_size[i];
                slot = i;
                return ST_OK;
            end
        end
        if (sh_count >= MAX_BLOCKS) return ST_NO_SPACE;
        need = longint'(sh_top) + META_BYTES + sz;
        if (need > longint'(cfg_cap)) return ST_NO_SPACE;
        slot = sh_count;
        sh_size[slot] = sz;
        sh_free[slot] = 1'b0;
        sh_off[slot] = sh_top + META_BYTES;
        sh_top = 32'(need);
        sh_used_bytes += sz;
        sh_count++;
        return ST_OK;
    endfunction

    function automatic void mark_free(input int unsigned h);
        sh_free[h] = 1'b1;
        sh_free_cnt++;
        sh_free_bytes += sh_size[h];
    endfunction

    function automatic t_grant predict_grant(input logic [1:0] rtype,
                                             input logic [SIZE_W-1:0] sz,
                                             input logic hv, input logic [IDX_W-1:0] h);
        t_grant g;
        int unsigned slot;
        logic granted;
        g.status = ST_NOP;
        slot = 0;
        granted = 1'b0;
        if (rtype == REQ_ALLOC || rtype == REQ_REALLOC) begin
            if (sz == 0 || sz > cfg_max_req) begin
                g.status = ST_BAD_SIZE;
            end else if (rtype == REQ_ALLOC || !hv) begin
                g.status = first_fit(sz, slot);
                granted = (g.status == ST_OK);
            end else if (h >= sh_count) begin
                g.status = ST_NOP;
            end else if (sz <= sh_size[h]) begin
                g.status = ST_OK;
                slot = h;
                granted = 1'b1;
            end else begin
                g.status = first_fit(sz, slot);
                if (g.status == ST_OK) begin
                    granted = 1'b1;
                    if (!sh_free[h]) mark_free(h);
                end
            end
        end else if (rtype == REQ_FREE) begin
            if (hv && h < sh_count && !sh_free[h]) begin
                mark_free(h);
                g.status = ST_OK;
            end
        end
        g.result_index = granted ? slot[IDX_W-1:0] : '0;
        g.payload_offset = granted ? sh_off[slot] : '0;
        g.free_blocks = sh_free_cnt[CNT_W-1:0];
        g.free_bytes = sh_free_bytes;
        g.allocated_blocks = sh_count[CNT_W-1:0];
        g.allocated_bytes = sh_used_bytes;
        return g;
    endfunction

    // request driver: random gap, then hold the beat until taken
    task automatic send_request(input logic [1:0] rtype, input logic [SIZE_W-1:0] sz,
                                input logic hv, input logic [IDX_W-1:0] h);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rtype;
        req_ch.req_size <= sz;
        req_ch.handle_valid <= hv;
        req_ch.block_handle <= h;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_grants.push_back(predict_grant(rtype, sz, hv, h));
        @(negedge i_clk);
    endtask

    // drop the request valid once no further beat follows
    task automatic stop_requests();
        req_ch.valid <= 1'b0;
    endtask

    // apb write: setup then access, only while idle
    task automatic write_register(input logic idx, input logic [31:0] val);
        stop_requests();
        wait (expected_grants.size() == 0);
        repeat (80) @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_MAX_REQUEST) cfg_max_req = val[SIZE_W-1:0];
        else cfg_cap = val;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic check_grant();
        t_grant e;
        if (expected_grants.size() == 0) begin
            $error("response beat with nothing expected");
            error_count++;
            return;
        end
        e = expected_grants.pop_front();
        if (rsp_ch.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, rsp_ch.status); error_count++;
        end
        if (rsp_ch.result_index !== e.result_index) begin
            $error("result_index exp %0d got %0d", e.result_index, rsp_ch.result_index);
            error_count++;
        end
        if (rsp_ch.payload_offset !== e.payload_offset) begin
            $error("payload_offset exp %0d got %0d", e.payload_offset, rsp_ch.payload_offset);
            error_count++;
        end
        if (rsp_ch.free_blocks !== e.free_blocks) begin
            $error("free_blocks exp %0d got %0d", e.free_blocks, rsp_ch.free_blocks);
            error_count++;
        end
        if (rsp_ch.free_bytes !== e.free_bytes) begin
            $error("free_bytes exp %0d got %0d", e.free_bytes, rsp_ch.free_bytes);
            error_count++;
        end
        if (rsp_ch.allocated_blocks !== e.allocated_blocks) begin
            $error("allocated_blocks exp %0d got %0d", e.allocated_blocks,
                   rsp_ch.allocated_blocks);
            error_count++;
        end
        if (rsp_ch.allocated_bytes !== e.allocated_bytes) begin
            $error("allocated_bytes exp %0d got %0d", e.allocated_bytes,
                   rsp_ch.allocated_bytes);
            error_count++;
        end
    endtask

    // response receiver: random stall drawn per beat
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, 3);
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            check_grant();
        end
    end

    // watchdog: ends the run as a failure if it does not finish; sized for ~1000 items
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // directed: edge sizes, every request type, null and stale handles
    task automatic test_directed();
        send_request(REQ_ALLOC, '0, 1'b0, '0);              // zero size
        send_request(REQ_ALLOC, {SIZE_W{1'b1}}, 1'b0, '0);  // above max_request
        send_request(REQ_ALLOC, 27'd1, 1'b0, '0);
        send_request(REQ_ALLOC, 27'd100, 1'b0, '0);
        send_request(REQ_ALLOC, 27'd2000000, 1'b0, '0);     // beyond capacity
        send_request(REQ_FREE, '0, 1'b0, '0);               // null free
        send_request(REQ_FREE, '0, 1'b1, 6'd63);            // index past count
        send_request(REQ_FREE, '0, 1'b1, 6'd1);
        send_request(REQ_FREE, '0, 1'b1, 6'd1);             // double free
        send_request(REQ_ALLOC, 27'd50, 1'b0, '0);          // reuses freed block
        send_request(REQ_REALLOC, 27'd80, 1'b1, 6'd1);      // fits in place
        send_request(REQ_REALLOC, 27'd500, 1'b1, 6'd0);     // moves, frees old
        send_request(REQ_REALLOC, 27'd1, 1'b1, 6'd0);       // keep a free block
        send_request(REQ_REALLOC, 27'd700, 1'b1, 6'd0);     // grow from free block
        send_request(REQ_REALLOC, 27'd10, 1'b0, '0);        // null acts as alloc
        send_request(REQ_REALLOC, 27'd10, 1'b1, 6'd62);     // stale handle
        send_request(REQ_REALLOC, '0, 1'b1, 6'd0);          // bad size first
        send_request(2'd3, {SIZE_W{1'b1}}, 1'b1, 6'd63);    // unknown type
    endtask

    // random traffic, mostly small sizes with a few big ones
    task automatic test_random(input int n);
        logic [1:0] rtype;
        logic [SIZE_W-1:0] sz;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            rtype = (pick < 45) ? REQ_ALLOC : (pick < 75) ? REQ_FREE :
                    (pick < 97) ? REQ_REALLOC : 2'd3;
            pick = $urandom_range(0, 99);
            sz = (pick < 80) ? SIZE_W'($urandom_range(1, 4000)) :
                 (pick < 90) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, 2));
            send_request(rtype, sz, ($urandom_range(0, 9) != 0),
                         IDX_W'($urandom_range(0, 63)));
        end
    endtask

    // register sweep: extremes of both registers, table fill to capacity
    task automatic test_config();
        write_register(REG_MAX_REQUEST, 32'd1);
        test_random(60);
        write_register(REG_MAX_REQUEST, 32'h07FF_FFFF);
        write_register(REG_HEAP_CAPACITY, 32'hFFFF_FFFF);
        test_random(250);
        write_register(REG_HEAP_CAPACITY, 32'd0);
        test_random(60);
        write_register(REG_MAX_REQUEST, 32'd5000);
        write_register(REG_HEAP_CAPACITY, 32'd3_000_000);
        test_random(200);
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_ALLOC;
        req_ch.req_size = '0;
        req_ch.handle_valid = 1'b0;
        req_ch.block_handle = '0;
        sh_count = 0; sh_top = 0; sh_free_cnt = 0; sh_free_bytes = 0; sh_used_bytes = 0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            sh_free[i] = 1'b0; sh_size[i] = '0; sh_off[i] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(360);
        test_config();
        stop_requests();
        wait (expected_grants.size() == 0);
        repeat (80) @(negedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

@@ files.f @@
design/ffba_pkg.sv
design/ffba_req_if.sv
design/ffba_rsp_if.sv
design/ffba_cell.sv
design/first_fit_block_allocator_top.sv
tb/tb.sv
